@@ src/bsa_pkg.sv @@
// Shared constants, codes and types for the bitmap slot allocator.
package bsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 256;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int MARK_W      = SLOT_W + 1;
    localparam int VALUE_WIDTH = 32;

    // Two-level hole search: groups of bits, then the bit inside a group
    localparam int GRP_SIZE  = 16;
    localparam int GRP_COUNT = SLOT_COUNT / GRP_SIZE;
    localparam int GRP_W     = $clog2(GRP_COUNT);
    localparam int LOW_W     = $clog2(GRP_SIZE);

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    // Control sequence
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_EXEC
    } state_t;

    // First-hole search result
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } hole_find_t;

endpackage

@@ src/bsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bsa_first_hole.sv @@
// Two-step first-fit search over the hole bitmap: lowest group, then lowest bit.
module bsa_first_hole (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           capture,
    input  logic [bsa_pkg::SLOT_COUNT-1:0] hole_map,
    output bsa_pkg::hole_find_t            find
);

    import bsa_pkg::*;

    logic [GRP_COUNT-1:0] grp_any;
    logic [GRP_W-1:0]     grp_sel;
    logic                 grp_found;
    logic [GRP_W-1:0]     grp_reg;
    logic [GRP_W-1:0]     grp_next;
    logic                 found_reg;
    logic                 found_next;
    logic [GRP_SIZE-1:0]  grp_bits;
    logic [LOW_W-1:0]     low_sel;

    // Flag groups that hold at least one hole
    always_comb
    begin
        for (int g = 0; g < GRP_COUNT; g++)
        begin
            grp_any[g] = |hole_map[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    // Pick the lowest group with a hole
    always_comb
    begin
        grp_sel   = '0;
        grp_found = 1'b0;
        for (int g = GRP_COUNT - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel   = GRP_W'(g);
                grp_found = 1'b1;
            end
        end
    end

    // Hold the group choice for the second step
    always_comb
    begin
        grp_next   = grp_reg;
        found_next = found_reg;
        if (capture)
        begin
            grp_next   = grp_sel;
            found_next = grp_found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            grp_reg   <= grp_next;
            found_reg <= found_next;
        end
    end

    // Pick the lowest hole inside the chosen group
    assign grp_bits = hole_map[grp_reg*GRP_SIZE +: GRP_SIZE];

    always_comb
    begin
        low_sel = '0;
        for (int b = GRP_SIZE - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                low_sel = LOW_W'(b);
            end
        end
    end

    assign find.found = found_reg;
    assign find.slot  = {grp_reg, low_sel};

endmodule

@@ src/bitmap_slot_allocator_unit.sv @@
// Top level of the bitmap slot allocator: control, bitmap, marks and slot memory.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: func; tdata: slot_index, push_value
//  m_axis    out  m_axis_tvalid/tready       tuser: status, is_hole; tdata: index, value
//  cfg       in   cfg_valid/cfg_ready        cfg_data: default_value
//
// A result is registered at the end of its item's update step: the slot memory read and
// the first-hole group search share the find step, the update takes the exec step.
// The input is ready only while idle, so a new item is accepted only after the last one's update.
// Reset clears the bitmap, marks and control state at once; the slot memory needs
// no clearing. The result register holds while m_axis is stalled; the next item
// is accepted meanwhile and waits in its update step until the result is taken.
module bitmap_slot_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] slot_index, [39:8] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] result_index, [39:8] read_value
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] is_hole
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import bsa_pkg::*;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [MARK_W-1:0]      hw_reg, hw_next;
    logic [MARK_W-1:0]      hc_reg, hc_next;
    logic [SLOT_COUNT-1:0]  hole_map_reg, hole_map_next;
    logic [VALUE_WIDTH-1:0] dflt_reg, dflt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]      out_index_reg, out_index_next;
    status_t                out_status_reg, out_status_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_hole_reg, out_hole_next;

    logic                   in_fire;
    logic                   go;
    logic                   idx_below;
    logic                   ram_wr_en;
    logic [SLOT_W-1:0]      ram_wr_addr;
    logic [VALUE_WIDTH-1:0] ram_wr_data;
    logic [VALUE_WIDTH-1:0] ram_rd_data;
    hole_find_t             find;

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign go            = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign idx_below     = ({1'b0, idx_reg} < hw_reg);

    // Slot memory
    bsa_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (s_axis_tdata[SLOT_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // First-fit search
    bsa_first_hole u_find (
        .clk      (clk),
        .rst_n    (rst_n),
        .capture  (state_reg == ST_FIND),
        .hole_map (hole_map_reg),
        .find     (find)
    );

    // Sequence, table update and result
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        hw_next         = hw_reg;
        hc_next         = hc_reg;
        hole_map_next   = hole_map_reg;
        dflt_next       = dflt_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_hole_next   = out_hole_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = val_reg;

        // Take a configuration write
        if (cfg_valid)
        begin
            dflt_next = cfg_data;
        end

        // Drop a delivered result
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next  = func_t'(s_axis_tuser);
                    idx_next   = s_axis_tdata[SLOT_W-1:0];
                    val_next   = s_axis_tdata[SLOT_W +: VALUE_WIDTH];
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_index_next  = idx_reg;
                    out_status_next = STAT_OK;
                    out_value_next  = '0;
                    out_hole_next   = 1'b0;
                    case (func_reg)
                        FUNC_PUSH:
                        begin
                            if (hc_reg != '0)
                            begin
                                // Fill the lowest hole
                                ram_wr_en                 = 1'b1;
                                ram_wr_addr               = find.slot;
                                hole_map_next[find.slot]  = 1'b0;
                                hc_next                   = hc_reg - 1'b1;
                                out_index_next            = find.slot;
                            end
                            else if (!hw_reg[SLOT_W])
                            begin
                                // Append at the mark
                                ram_wr_en      = 1'b1;
                                ram_wr_addr    = hw_reg[SLOT_W-1:0];
                                hw_next        = hw_reg + 1'b1;
                                out_index_next = hw_reg[SLOT_W-1:0];
                            end
                            else
                            begin
                                out_index_next  = '0;
                                out_status_next = STAT_FULL;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            out_hole_next = 1'b1;
                            if (!idx_below || hole_map_reg[idx_reg])
                            begin
                                out_status_next = STAT_BAD;
                            end
                            else
                            begin
                                ram_wr_en              = 1'b1;
                                ram_wr_data            = dflt_reg;
                                hole_map_next[idx_reg] = 1'b1;
                                hc_next                = hc_reg + 1'b1;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (!idx_below)
                            begin
                                out_status_next = STAT_BAD;
                                out_hole_next   = 1'b1;
                            end
                            else
                            begin
                                out_value_next = ram_rd_data;
                                out_hole_next  = hole_map_reg[idx_reg];
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            // Slots above the mark are never read, so the store keeps its data
                            out_index_next = '0;
                            hole_map_next  = '0;
                            hw_next        = '0;
                            hc_next        = '0;
                        end
                        default:
                        begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hw_reg        <= '0;
            hc_reg        <= '0;
            hole_map_reg  <= '0;
            dflt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            hc_reg        <= hc_next;
            hole_map_reg  <= hole_map_next;
            dflt_reg      <= dflt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_hole_reg   <= out_hole_next;
    end

    // Result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_index_reg};
    assign m_axis_tuser  = {out_hole_reg, out_status_reg};

endmodule

@@ tb/tb_bitmap_slot_allocator_unit.sv @@
// Self-checking testbench for the bitmap slot allocator: push, remove, read and clear items.
module tb_bitmap_slot_allocator_unit;
    import bsa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;

    // Expected result of one item
    typedef struct packed {
        logic [7:0]             index;
        status_t                status;
        logic [VALUE_WIDTH-1:0] value;
        logic                   hole;
    } slot_reply_t;

    // Tracks the slot table and the results still owed by the block
    class alloc_board;
        logic [VALUE_WIDTH-1:0] store [SLOT_COUNT];
        bit                     hole  [SLOT_COUNT];
        int                     mark;
        int                     holes;
        logic [VALUE_WIDTH-1:0] dflt;
        slot_reply_t            replies_due [$];
        int                     errors;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                store[i] = '0;
                hole[i]  = 1'b0;
            end
            mark   = 0;
            holes  = 0;
            dflt   = '0;
            errors = 0;
        endfunction

        // Apply one accepted item to the table and queue its result
        function void accept_op(func_t f, logic [7:0] idx, logic [VALUE_WIDTH-1:0] val);
            slot_reply_t r;
            bit          placed;
            r.index  = 8'd0;
            r.status = STAT_OK;
            r.value  = '0;
            r.hole   = 1'b0;
            placed   = 1'b0;
            case (f)
                FUNC_PUSH:
                begin
                    // first fit into a hole, else append at the mark
                    if (holes > 0)
                    begin
                        for (int i = 0; i < mark; i++)
                        begin
                            if (!placed && hole[i])
                            begin
                                store[i] = val;
                                hole[i]  = 1'b0;
                                holes--;
                                r.index  = i[7:0];
                                placed   = 1'b1;
                            end
                        end
                    end
                    if (!placed)
                    begin
                        if (mark < SLOT_COUNT)
                        begin
                            store[mark] = val;
                            hole[mark]  = 1'b0;
                            r.index     = mark[7:0];
                            mark++;
                        end
                        else
                            r.status = STAT_FULL;
                    end
                end
                FUNC_REMOVE:
                begin
                    r.index = idx;
                    r.hole  = 1'b1;
                    if (idx >= mark || hole[idx])
                        r.status = STAT_BAD;
                    else
                    begin
                        store[idx] = dflt;
                        hole[idx]  = 1'b1;
                        holes++;
                    end
                end
                FUNC_READ:
                begin
                    r.index = idx;
                    if (idx >= mark)
                    begin
                        r.status = STAT_BAD;
                        r.hole   = 1'b1;
                    end
                    else
                    begin
                        r.value = store[idx];
                        r.hole  = hole[idx];
                    end
                end
                default:
                begin
                    // clear: every slot takes the default value
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        store[i] = dflt;
                        hole[i]  = 1'b0;
                    end
                    mark  = 0;
                    holes = 0;
                end
            endcase
            replies_due.push_back(r);
        endfunction

        // Compare one result item with the oldest expectation
        function void check_reply(logic [7:0] idx, logic [1:0] st,
                                  logic [VALUE_WIDTH-1:0] val, logic h);
            slot_reply_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: index %0d status %0d value %h hole %0b",
                             idx, st, val, h);
                return;
            end
            want = replies_due.pop_front();
            if (want.index !== idx || want.status !== st || want.value !== val ||
                want.hole !== h)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected index %0d status %0d value %h hole %0b",
                             want.index, want.status, want.value, want.hole);
                    $display("               got index %0d status %0d value %h hole %0b",
                             idx, st, val, h);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    alloc_board board;
    int         cycles;
    int         burst_left;
    int         stall_mode;
    int         stall_left;

    bitmap_slot_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Guard against a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the result side: always ready, coin flips, one in four, or long runs
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (cycles % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0) ? ~m_axis_tready
                                                                  : m_axis_tready;
        endcase
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reply(m_axis_tdata[7:0], m_axis_tuser[1:0],
                              m_axis_tdata[39:8], m_axis_tuser[2]);
    end

    // Send one item, with a random gap at the start of each burst
    task automatic send_op(input func_t f, input logic [7:0] idx, input logic [31:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx};
        s_axis_tuser  <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.accept_op(f, idx, val);
    endtask

    // Hold off input until every owed result has arrived
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the default value register; only called while idle
    task automatic write_default(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.dflt = v;
    endtask

    // Random item, addressing mostly slots below the mark
    task automatic random_op(input int clear_odds);
        int         pick;
        func_t      f;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < clear_odds)
            f = FUNC_CLEAR;
        else if (pick < 45)
            f = FUNC_PUSH;
        else if (pick < 72)
            f = FUNC_REMOVE;
        else
            f = FUNC_READ;
        if (board.mark > 0 && $urandom_range(0, 9) < 7)
            idx = 8'($urandom_range(0, board.mark - 1));
        else
            idx = 8'($urandom_range(0, 255));
        send_op(f, idx, $urandom);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_PUSH;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cycles        = 0;
        burst_left    = 0;
        stall_mode    = 0;
        stall_left    = 0;
        board         = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, appends, holes, double remove, clear
        write_default(32'hA5A5_5A5A);
        send_op(FUNC_READ,   8'd0,   32'h0);
        send_op(FUNC_READ,   8'd255, 32'h0);
        send_op(FUNC_REMOVE, 8'd0,   32'h0);
        send_op(FUNC_PUSH,   8'd255, 32'h0000_0000);
        send_op(FUNC_PUSH,   8'd0,   32'hFFFF_FFFF);
        send_op(FUNC_PUSH,   8'd7,   32'h1234_5678);
        send_op(FUNC_READ,   8'd1,   32'h0);
        send_op(FUNC_REMOVE, 8'd1,   32'h0);
        send_op(FUNC_REMOVE, 8'd1,   32'h0);
        send_op(FUNC_REMOVE, 8'd3,   32'h0);
        send_op(FUNC_READ,   8'd1,   32'h0);
        send_op(FUNC_READ,   8'd3,   32'h0);
        send_op(FUNC_REMOVE, 8'd0,   32'h0);
        send_op(FUNC_PUSH,   8'd0,   32'h8000_0001);
        send_op(FUNC_PUSH,   8'd0,   32'h7FFF_FFFE);
        send_op(FUNC_PUSH,   8'd0,   32'hDEAD_BEEF);
        send_op(FUNC_READ,   8'd0,   32'h0);
        send_op(FUNC_CLEAR,  8'd0,   32'h0);
        send_op(FUNC_READ,   8'd0,   32'h0);
        send_op(FUNC_PUSH,   8'd0,   32'h0F0F_0F0F);
        send_op(FUNC_REMOVE, 8'd255, 32'h0);
        drain_all();
        write_default(32'hFFFF_FFFF);
        send_op(FUNC_REMOVE, 8'd0,   32'h0);
        send_op(FUNC_READ,   8'd0,   32'h0);
        drain_all();
        write_default(32'h0000_0000);
        send_op(FUNC_CLEAR,  8'd0,   32'h0);
        drain_all();

        // Random mix with a random default
        write_default($urandom);
        for (int n = 0; n < 200; n++)
        begin
            random_op(2);
            if (n % 70 == 69)
                drain_all();
        end
        drain_all();

        // Fill the table to the top, then push against a full table
        write_default(32'h0000_0000);
        send_op(FUNC_CLEAR, 8'd0, 32'h0);
        while (board.mark < SLOT_COUNT || board.holes > 0)
        begin
            if ($urandom_range(0, 9) < 8)
                send_op(FUNC_PUSH, 8'($urandom), $urandom);
            else
                random_op(0);
        end
        repeat (5) send_op(FUNC_PUSH, 8'($urandom), $urandom);
        send_op(FUNC_READ,   8'd255, 32'h0);
        send_op(FUNC_REMOVE, 8'd255, 32'h0);
        send_op(FUNC_READ,   8'd255, 32'h0);
        send_op(FUNC_PUSH,   8'd0,   $urandom);
        send_op(FUNC_PUSH,   8'd0,   $urandom);
        for (int n = 0; n < 40; n++)
            random_op(0);
        drain_all();

        // Random mix with all-ones default and occasional clears
        write_default(32'hFFFF_FFFF);
        for (int n = 0; n < 100; n++)
            random_op(3);

        drain_all();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.replies_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
